@@ hdl/mic_pkg.sv @@
// shared types, identity codes and opcode tables for the mips instruction classifier
package mic_pkg;

    // instruction identity
    typedef logic [6:0] id_t;

    // identity codes, numbered in name-list order
    localparam id_t ID_ADD      = 7'd0;
    localparam id_t ID_ADDU     = 7'd1;
    localparam id_t ID_ADDI     = 7'd2;
    localparam id_t ID_ADDIU    = 7'd3;
    localparam id_t ID_AND      = 7'd4;
    localparam id_t ID_ANDI     = 7'd5;
    localparam id_t ID_DIV      = 7'd6;
    localparam id_t ID_DIVU     = 7'd7;
    localparam id_t ID_MULT     = 7'd8;
    localparam id_t ID_MULTU    = 7'd9;
    localparam id_t ID_NOR      = 7'd10;
    localparam id_t ID_OR       = 7'd11;
    localparam id_t ID_ORI      = 7'd12;
    localparam id_t ID_SLL      = 7'd13;
    localparam id_t ID_SLLV     = 7'd14;
    localparam id_t ID_SRA      = 7'd15;
    localparam id_t ID_SRAV     = 7'd16;
    localparam id_t ID_SRL      = 7'd17;
    localparam id_t ID_SRLV     = 7'd18;
    localparam id_t ID_SUB      = 7'd19;
    localparam id_t ID_SUBU     = 7'd20;
    localparam id_t ID_XOR      = 7'd21;
    localparam id_t ID_XORI     = 7'd22;
    localparam id_t ID_LUI      = 7'd23;
    localparam id_t ID_SLT      = 7'd24;
    localparam id_t ID_SLTU     = 7'd25;
    localparam id_t ID_SLTI     = 7'd26;
    localparam id_t ID_SLTIU    = 7'd27;
    localparam id_t ID_BEQ      = 7'd28;
    localparam id_t ID_BNE      = 7'd29;
    localparam id_t ID_BGTZ     = 7'd30;
    localparam id_t ID_BLEZ     = 7'd31;
    localparam id_t ID_BGEZ     = 7'd32;
    localparam id_t ID_BGEZAL   = 7'd33;
    localparam id_t ID_BLTZ     = 7'd34;
    localparam id_t ID_BLTZAL   = 7'd35;
    localparam id_t ID_J        = 7'd36;
    localparam id_t ID_JAL      = 7'd37;
    localparam id_t ID_JR       = 7'd38;
    localparam id_t ID_JALR     = 7'd39;
    localparam id_t ID_SYSCALL  = 7'd40;
    localparam id_t ID_BREAK    = 7'd41;
    localparam id_t ID_LB       = 7'd42;
    localparam id_t ID_LBU      = 7'd43;
    localparam id_t ID_LH       = 7'd44;
    localparam id_t ID_LHU      = 7'd45;
    localparam id_t ID_LW       = 7'd46;
    localparam id_t ID_LWL      = 7'd47;
    localparam id_t ID_LWR      = 7'd48;
    localparam id_t ID_LWC      = 7'd49;
    localparam id_t ID_SB       = 7'd50;
    localparam id_t ID_SH       = 7'd51;
    localparam id_t ID_SW       = 7'd52;
    localparam id_t ID_SWL      = 7'd53;
    localparam id_t ID_SWR      = 7'd54;
    localparam id_t ID_SWC      = 7'd55;
    localparam id_t ID_MFHI     = 7'd56;
    localparam id_t ID_MFLO     = 7'd57;
    localparam id_t ID_MTHI     = 7'd58;
    localparam id_t ID_MTLO     = 7'd59;
    localparam id_t ID_COP      = 7'd60;
    localparam id_t ID_MFC      = 7'd61;
    localparam id_t ID_CFC      = 7'd62;
    localparam id_t ID_MTC      = 7'd63;
    localparam id_t ID_CTC      = 7'd64;
    localparam id_t ID_NOP      = 7'd65;
    localparam id_t ID_BCF      = 7'd66;
    localparam id_t ID_BCFL     = 7'd67;
    localparam id_t ID_BCT      = 7'd68;
    localparam id_t ID_BCTL     = 7'd69;
    localparam id_t ID_BEQL     = 7'd70;
    localparam id_t ID_BNEL     = 7'd71;
    localparam id_t ID_BGEZL    = 7'd72;
    localparam id_t ID_BGEZALL  = 7'd73;
    localparam id_t ID_BGTZL    = 7'd74;
    localparam id_t ID_BLEZL    = 7'd75;
    localparam id_t ID_BLTZL    = 7'd76;
    localparam id_t ID_BLTZALL  = 7'd77;
    localparam id_t ID_CACHE    = 7'd78;
    localparam id_t ID_DADD     = 7'd79;
    localparam id_t ID_DADDU    = 7'd80;
    localparam id_t ID_DADDI    = 7'd81;
    localparam id_t ID_DADDIU   = 7'd82;
    localparam id_t ID_DSUB     = 7'd83;
    localparam id_t ID_DSUBU    = 7'd84;
    localparam id_t ID_DMULT    = 7'd85;
    localparam id_t ID_DMULTU   = 7'd86;
    localparam id_t ID_DDIV     = 7'd87;
    localparam id_t ID_DDIVU    = 7'd88;
    localparam id_t ID_DSLL     = 7'd89;
    localparam id_t ID_DSLL32   = 7'd90;
    localparam id_t ID_DSLLV    = 7'd91;
    localparam id_t ID_DSRA     = 7'd92;
    localparam id_t ID_DSRA32   = 7'd93;
    localparam id_t ID_DSRAV    = 7'd94;
    localparam id_t ID_DSRL     = 7'd95;
    localparam id_t ID_DSRL32   = 7'd96;
    localparam id_t ID_DSRLV    = 7'd97;
    localparam id_t ID_DMFC     = 7'd98;
    localparam id_t ID_DMTC     = 7'd99;
    localparam id_t ID_LD       = 7'd100;
    localparam id_t ID_LDC      = 7'd101;
    localparam id_t ID_LDL      = 7'd102;
    localparam id_t ID_LDR      = 7'd103;
    localparam id_t ID_LWU      = 7'd104;
    localparam id_t ID_SD       = 7'd105;
    localparam id_t ID_SDC      = 7'd106;
    localparam id_t ID_SDL      = 7'd107;
    localparam id_t ID_SDR      = 7'd108;
    localparam id_t ID_LL       = 7'd109;
    localparam id_t ID_LLD      = 7'd110;
    localparam id_t ID_SC       = 7'd111;
    localparam id_t ID_SCD      = 7'd112;
    localparam id_t ID_SYNC     = 7'd113;
    localparam id_t ID_UNK      = 7'd114;

    // primary opcodes decoded outside the primary table
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_COP1    = 6'h11;
    localparam logic [5:0] OP_COP2    = 6'h12;
    localparam logic [5:0] OP_COP3    = 6'h13;
    localparam logic [5:0] OP_LL      = 6'h30;
    localparam logic [5:0] OP_LWC3    = 6'h33;
    localparam logic [5:0] OP_SC      = 6'h38;
    localparam logic [5:0] OP_SWC3    = 6'h3B;

    // special functs checked for nop and sync
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SYNC = 6'h0F;

    // coprocessor rs codes
    localparam logic [4:0] RS_MF  = 5'd0;
    localparam logic [4:0] RS_DMF = 5'd1;
    localparam logic [4:0] RS_CF  = 5'd2;
    localparam logic [4:0] RS_MT  = 5'd4;
    localparam logic [4:0] RS_DMT = 5'd5;
    localparam logic [4:0] RS_CT  = 5'd6;
    localparam logic [4:0] RS_BC  = 5'd8;

    // coprocessor branch rt codes
    localparam logic [4:0] RT_BCF  = 5'd0;
    localparam logic [4:0] RT_BCT  = 5'd1;
    localparam logic [4:0] RT_BCFL = 5'd2;
    localparam logic [4:0] RT_BCTL = 5'd3;

    // regimm rt bits that select the branch form
    localparam int REGIMM_GE_BIT     = 16;
    localparam int REGIMM_LIKELY_BIT = 17;
    localparam int REGIMM_LINK_BIT   = 20;

    // reset value of the 64-bit enable
    localparam logic ALLOW_64BIT_RESET = 1'b1;

    // table entry: identity plus a mark for forms that need the 64-bit enable
    typedef struct packed {
        logic gated;
        id_t  id;
    } tab_entry_t;

    // decoded result word
    typedef struct packed {
        id_t  inst_id;
        logic is_branch;
        logic has_delay_slot;
    } result_t;

    function automatic tab_entry_t ent(input id_t id);
        ent = '{gated: 1'b0, id: id};
    endfunction

    function automatic tab_entry_t gent(input id_t id);
        gent = '{gated: 1'b1, id: id};
    endfunction

    // primary opcode table
    function automatic tab_entry_t primary_entry(input logic [5:0] op);
        tab_entry_t e;
        e = ent(ID_UNK);
        unique case (op)
            6'h02: e = ent(ID_J);
            6'h03: e = ent(ID_JAL);
            6'h04: e = ent(ID_BEQ);
            6'h05: e = ent(ID_BNE);
            6'h06: e = ent(ID_BLEZ);
            6'h07: e = ent(ID_BGTZ);
            6'h08: e = ent(ID_ADDI);
            6'h09: e = ent(ID_ADDIU);
            6'h0A: e = ent(ID_SLTI);
            6'h0B: e = ent(ID_SLTIU);
            6'h0C: e = ent(ID_ANDI);
            6'h0D: e = ent(ID_ORI);
            6'h0E: e = ent(ID_XORI);
            6'h0F: e = ent(ID_LUI);
            6'h14: e = gent(ID_BEQL);
            6'h15: e = gent(ID_BNEL);
            6'h16: e = gent(ID_BLEZL);
            6'h17: e = gent(ID_BGTZL);
            6'h18: e = gent(ID_DADDI);
            6'h19: e = gent(ID_DADDIU);
            6'h1A: e = ent(ID_LDL);
            6'h1B: e = ent(ID_LDR);
            6'h20: e = ent(ID_LB);
            6'h21: e = ent(ID_LH);
            6'h22: e = ent(ID_LWL);
            6'h23: e = ent(ID_LW);
            6'h24: e = ent(ID_LBU);
            6'h25: e = ent(ID_LHU);
            6'h26: e = ent(ID_LWR);
            6'h27: e = gent(ID_LWU);
            6'h28: e = ent(ID_SB);
            6'h29: e = ent(ID_SH);
            6'h2A: e = ent(ID_SWL);
            6'h2B: e = ent(ID_SW);
            6'h2C: e = gent(ID_SDL);
            6'h2D: e = gent(ID_SDR);
            6'h2E: e = ent(ID_SWR);
            6'h2F: e = gent(ID_CACHE);
            6'h31: e = ent(ID_LWC);
            6'h32: e = ent(ID_LWC);
            6'h34: e = gent(ID_LLD);
            6'h35: e = gent(ID_LDC);
            6'h36: e = gent(ID_LDC);
            6'h37: e = gent(ID_LD);
            6'h39: e = ent(ID_SWC);
            6'h3A: e = ent(ID_SWC);
            6'h3C: e = gent(ID_SCD);
            6'h3D: e = gent(ID_SDC);
            6'h3E: e = gent(ID_SDC);
            6'h3F: e = ent(ID_SD);
            default: e = ent(ID_UNK);
        endcase
        return e;
    endfunction

    // special-function table
    function automatic tab_entry_t funct_entry(input logic [5:0] fn);
        tab_entry_t e;
        e = ent(ID_UNK);
        unique case (fn)
            6'h00: e = ent(ID_SLL);
            6'h02: e = ent(ID_SRL);
            6'h03: e = ent(ID_SRA);
            6'h04: e = ent(ID_SLLV);
            6'h06: e = ent(ID_SRLV);
            6'h07: e = ent(ID_SRAV);
            6'h08: e = ent(ID_JR);
            6'h09: e = ent(ID_JALR);
            6'h0C: e = ent(ID_SYSCALL);
            6'h0D: e = ent(ID_BREAK);
            6'h10: e = ent(ID_MFHI);
            6'h11: e = ent(ID_MTHI);
            6'h12: e = ent(ID_MFLO);
            6'h13: e = ent(ID_MTLO);
            6'h14: e = gent(ID_DSLLV);
            6'h16: e = gent(ID_DSRLV);
            6'h17: e = gent(ID_DSRAV);
            6'h18: e = ent(ID_MULT);
            6'h19: e = ent(ID_MULTU);
            6'h1A: e = ent(ID_DIV);
            6'h1B: e = ent(ID_DIVU);
            6'h1C: e = gent(ID_DMULT);
            6'h1D: e = gent(ID_DMULTU);
            6'h1E: e = gent(ID_DDIV);
            6'h1F: e = gent(ID_DDIVU);
            6'h20: e = ent(ID_ADD);
            6'h21: e = ent(ID_ADDU);
            6'h22: e = ent(ID_SUB);
            6'h23: e = ent(ID_SUBU);
            6'h24: e = ent(ID_AND);
            6'h25: e = ent(ID_OR);
            6'h26: e = ent(ID_XOR);
            6'h27: e = ent(ID_NOR);
            6'h2A: e = ent(ID_SLT);
            6'h2B: e = ent(ID_SLTU);
            6'h2C: e = gent(ID_DADD);
            6'h2D: e = gent(ID_DADDU);
            6'h2E: e = gent(ID_DSUB);
            6'h2F: e = gent(ID_DSUBU);
            6'h38: e = gent(ID_DSLL);
            6'h3A: e = gent(ID_DSRL);
            6'h3B: e = gent(ID_DSRA);
            6'h3C: e = gent(ID_DSLL32);
            6'h3E: e = gent(ID_DSRL32);
            6'h3F: e = gent(ID_DSRA32);
            default: e = ent(ID_UNK);
        endcase
        return e;
    endfunction

    // gated entries fall to unknown while 64-bit forms are off
    function automatic id_t resolve(input tab_entry_t e, input logic allow64);
        id_t r;
        r = e.id;
        if (e.gated && !allow64)
        begin
            r = ID_UNK;
        end
        return r;
    endfunction

endpackage

@@ hdl/mic_decode.sv @@
// combinational decode of one instruction word into identity and branch flags
module mic_decode (
    input  logic [31:0]       instruction_word,
    input  logic              allow_64bit_ops,
    output mic_pkg::result_t  result
);
    import mic_pkg::*;

    logic [5:0] op;
    logic [5:0] fn;
    logic [4:0] shamt;
    logic [4:0] rd;
    logic [4:0] rs;
    logic [4:0] rt;
    logic       ge;
    logic       likely;
    logic       link;
    id_t        special_id;
    id_t        regimm_id;
    id_t        cop_id;
    id_t        id;
    logic       br;

    // instruction fields
    assign op     = instruction_word[31:26];
    assign rs     = instruction_word[25:21];
    assign rt     = instruction_word[20:16];
    assign rd     = instruction_word[15:11];
    assign shamt  = instruction_word[10:6];
    assign fn     = instruction_word[5:0];
    assign ge     = instruction_word[REGIMM_GE_BIT];
    assign likely = instruction_word[REGIMM_LIKELY_BIT];
    assign link   = instruction_word[REGIMM_LINK_BIT];

    // special table with nop and sync ignoring rs and rt
    always_comb
    begin
        special_id = resolve(funct_entry(fn), allow_64bit_ops);
        if (shamt == 5'd0 && rd == 5'd0)
        begin
            if (fn == FN_SLL)
            begin
                special_id = ID_NOP;
            end
            else if (fn == FN_SYNC)
            begin
                special_id = ID_SYNC;
            end
        end
    end

    // regimm branches
    always_comb
    begin
        if (likely)
        begin
            if (!allow_64bit_ops)
            begin
                regimm_id = ID_UNK;
            end
            else if (ge)
            begin
                regimm_id = link ? ID_BGEZALL : ID_BGEZL;
            end
            else
            begin
                regimm_id = link ? ID_BLTZALL : ID_BLTZL;
            end
        end
        else if (ge)
        begin
            regimm_id = link ? ID_BGEZAL : ID_BGEZ;
        end
        else
        begin
            regimm_id = link ? ID_BLTZAL : ID_BLTZ;
        end
    end

    // coprocessor forms by rs, anything unlisted is generic cop
    always_comb
    begin
        unique case (rs)
            RS_MF:   cop_id = ID_MFC;
            RS_DMF:  cop_id = allow_64bit_ops ? ID_DMFC : ID_UNK;
            RS_CF:   cop_id = ID_CFC;
            RS_MT:   cop_id = ID_MTC;
            RS_DMT:  cop_id = allow_64bit_ops ? ID_DMTC : ID_UNK;
            RS_CT:   cop_id = ID_CTC;
            RS_BC:
            begin
                if (!allow_64bit_ops)
                begin
                    cop_id = ID_UNK;
                end
                else
                begin
                    unique case (rt)
                        RT_BCF:  cop_id = ID_BCF;
                        RT_BCT:  cop_id = ID_BCT;
                        RT_BCFL: cop_id = ID_BCFL;
                        RT_BCTL: cop_id = ID_BCTL;
                        default: cop_id = ID_UNK;
                    endcase
                end
            end
            default: cop_id = ID_COP;
        endcase
    end

    // primary opcode selection
    always_comb
    begin
        unique case (op)
            OP_SPECIAL: id = special_id;
            OP_REGIMM:  id = regimm_id;
            OP_COP0, OP_COP1, OP_COP2, OP_COP3: id = cop_id;
            OP_LL:      id = allow_64bit_ops ? ID_LL : ID_LWC;
            OP_LWC3:    id = allow_64bit_ops ? ID_UNK : ID_LWC;
            OP_SC:      id = allow_64bit_ops ? ID_SC : ID_SWC;
            OP_SWC3:    id = allow_64bit_ops ? ID_UNK : ID_SWC;
            default:    id = resolve(primary_entry(op), allow_64bit_ops);
        endcase
    end

    // branch and delay-slot flags
    assign br = (id >= ID_BEQ && id <= ID_BREAK) || (id >= ID_BCF && id <= ID_BLTZALL);

    assign result.inst_id        = id;
    assign result.is_branch      = br;
    assign result.has_delay_slot = br && (id != ID_SYSCALL) && (id != ID_BREAK);

endmodule

@@ hdl/mips_instruction_classifier.sv @@
// top level: input register, decode and result register of the instruction classifier
// an accepted word is held in the input register, then decoded into the result register, where its result is valid
// throughput: one word per cycle while the result is not stalled, set by the input and result registers moving together
// a stalled result holds the result register and, once the input register is full, the input
// reset clears both valid flags and sets allow_64bit_ops to 1
module mips_instruction_classifier (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        inst_valid,
    output logic        inst_stall,
    input  logic [31:0] instruction_word,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [6:0]  inst_id,
    output logic        is_branch,
    output logic        has_delay_slot
);
    import mic_pkg::*;

    logic        allow_64bit_reg;
    logic        word_valid_reg;
    logic        word_valid_next;
    logic [31:0] word_reg;
    logic        res_valid_reg;
    logic        res_valid_next;
    result_t     res_reg;
    result_t     decoded;
    logic        res_load;
    logic        word_load;

    // 64-bit enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_64bit_reg <= ALLOW_64BIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            allow_64bit_reg <= cfg_wr_data;
        end
    end

    // pipeline advance control
    assign res_load        = !res_valid_reg || !res_stall;
    assign inst_stall      = word_valid_reg && !res_load;
    assign word_load       = inst_valid && !inst_stall;
    assign word_valid_next = word_load || (word_valid_reg && !res_load);
    assign res_valid_next  = res_load ? word_valid_reg : res_valid_reg;

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
        end
        else
        begin
            word_valid_reg <= word_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_load)
        begin
            word_reg <= instruction_word;
        end
    end

    // decode between the two registers
    mic_decode u_decode (
        .instruction_word (word_reg),
        .allow_64bit_ops  (allow_64bit_reg),
        .result           (decoded)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load && word_valid_reg)
        begin
            res_reg <= decoded;
        end
    end

    // outputs
    assign res_valid      = res_valid_reg;
    assign inst_id        = res_reg.inst_id;
    assign is_branch      = res_reg.is_branch;
    assign has_delay_slot = res_reg.has_delay_slot;

endmodule
